FILE: src/bba_pkg.sv
// Shared types and constants for the bitmap block allocator.
// Holds the beat structs, the command and status codes, and the free-bit pick function.
// No dependencies.
`default_nettype none

package bba_pkg;

  localparam int CMD_W    = 2;
  localparam int BLOCK_W  = 13;
  localparam int LIDX_W   = 10;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int BITS_W   = 14;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

  localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BLOCK_W-1:0] block_number;
    logic [LIDX_W-1:0]  load_index;
    logic [BYTE_W-1:0]  load_value;
  } bba_in_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]  allocated_block;
    logic [STATUS_W-1:0] status;
  } bba_out_t;

  // Write request into the bitmap store
  typedef struct packed {
    logic              we;
    logic [BYTE_W-1:0] wdata;
  } bba_wr_t;

  // Position of the lowest clear bit of a byte (0 when the byte is full)
  function automatic logic [2:0] first_clear(input logic [BYTE_W-1:0] v);
    logic [2:0] pos;
    logic       found;
    pos   = 3'd0;
    found = 1'b0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (!found && !v[k]) begin
        pos   = 3'(k);
        found = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

FILE: src/bba_store.sv
// Byte-wide bitmap store with one shared address, registered read data,
// and a clearing sweep after reset. Depends on bba_pkg.
`default_nettype none

module bba_store #(
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [AW-1:0]              addr,
  input  wire bba_pkg::bba_wr_t           wr,
  output logic [bba_pkg::BYTE_W-1:0]      rdata,
  output logic                            busy
);
  import bba_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [AW-1:0]     clr_addr;

  // Sweep every entry to zero once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Write port shared by the sweep and the sequencer; read at the same address
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr.we) begin
      mem[addr] <= wr.wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: src/bitmap_block_allocator_core.sv
// First-fit bitmap block allocator: top level with command sequencer and output register.
// Depends on bba_pkg and bba_store.
//
// Usage:
//   Commands arrive on in_valid/in_ready as bba_in_t beats; one result beat per
//   command leaves on out_valid/out_ready as bba_out_t. cfg_we/cfg_wdata write
//   bitmap_bits; write it only while no command is in flight.
//   Allocate scans the bitmap one byte at a time through the single store port,
//   each byte taking a read step (S_SCAN_RD) and a check step (S_SCAN_CHK); the
//   scan covers up to bitmap_bits/8 bytes, clamped to MAX_BITMAP_BYTES, and ends
//   with ST_NOFREE when all bytes in range are full. Free goes through read,
//   modify-write and result steps, load through a write step and a result step,
//   and an out-of-range or unused command goes straight to the result step.
//   One command is in work at a time; in_ready is low while it runs.
//   After reset the store is swept to zero, one byte per cycle, and in_ready stays
//   low until the sweep ends; cfg writes are taken during that time.
//   A finished result waits in the output register while out_ready is low; the
//   next command may be accepted meanwhile, and its result holds until the
//   register empties.
`default_nettype none

module bitmap_block_allocator_core #(
  parameter int MAX_BITMAP_BYTES = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire bba_pkg::bba_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output bba_pkg::bba_out_t                  out_data,
  input  wire logic                          cfg_we,
  input  wire logic [bba_pkg::BITS_W-1:0]    cfg_wdata
);
  import bba_pkg::*;

  localparam int AW  = (MAX_BITMAP_BYTES > 1) ? $clog2(MAX_BITMAP_BYTES) : 1;
  localparam int CW  = $clog2(MAX_BITMAP_BYTES + 1);
  localparam int WW  = (CW > 11) ? CW : 11;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_BITMAP_BYTES);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_FREE_RD, S_FREE_WR, S_LOAD, S_DONE
  } state_t;

  state_t               state;
  logic [BITS_W-1:0]    bitmap_bits;
  logic [CW-1:0]        ptr;
  logic [WW-1:0]        nbytes;
  logic [2:0]           bitsel;
  logic [BYTE_W-1:0]    ldval;
  logic [BLOCK_W-1:0]   res_blk;
  logic [STATUS_W-1:0]  res_status;

  logic [BYTE_W-1:0]    rdata;
  logic                 clr_busy;
  bba_wr_t              wr;
  logic [2:0]           pick;
  logic [AW+2:0]        blk_wide;
  logic [WW-1:0]        nbytes_raw;
  logic [WW-1:0]        free_byte;
  logic                 free_bad;
  logic                 load_bad;
  logic                 accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign pick     = first_clear(rdata);
  assign blk_wide = {ptr[AW-1:0], pick};

  // Limits computed from the incoming beat and the configured bit count
  assign nbytes_raw = WW'(bitmap_bits >> 3);
  assign free_byte  = WW'(in_data.block_number >> 3);
  assign free_bad   = ({1'b0, in_data.block_number} >= bitmap_bits) || (free_byte >= MAX_W);
  assign load_bad   = WW'(in_data.load_index) >= MAX_W;

  // Store access for the current step
  always_comb begin
    wr.we    = 1'b0;
    wr.wdata = rdata;
    unique case (state)
      S_SCAN_CHK: begin
        if (rdata != FULL_BYTE) begin
          wr.we    = 1'b1;
          wr.wdata = rdata | (8'b1 << pick);
        end
      end
      S_FREE_WR: begin
        wr.we    = 1'b1;
        wr.wdata = rdata & ~(8'b1 << bitsel);
      end
      S_LOAD: begin
        wr.we    = 1'b1;
        wr.wdata = ldval;
      end
      default: begin
        wr.we = 1'b0;
      end
    endcase
  end

  bba_store #(
    .DEPTH(MAX_BITMAP_BYTES)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .addr  (ptr[AW-1:0]),
    .wr    (wr),
    .rdata (rdata),
    .busy  (clr_busy)
  );

  // Hold the bit count register
  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap_bits <= '0;
    end else if (cfg_we) begin
      bitmap_bits <= cfg_wdata;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
      ptr       <= '0;
    end else begin
      // Load the output beat when a result is ready, drop it once taken
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (!clr_busy) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_blk    <= '0;
            res_status <= ST_DONE;
            bitsel     <= in_data.block_number[2:0];
            ldval      <= in_data.load_value;
            nbytes     <= (nbytes_raw >= MAX_W) ? MAX_W : nbytes_raw;
            case (in_data.cmd)
              CMD_ALLOC: begin
                ptr   <= '0;
                state <= S_SCAN_RD;
              end
              CMD_FREE: begin
                if (free_bad) begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  ptr   <= CW'(free_byte);
                  state <= S_FREE_RD;
                end
              end
              CMD_LOAD: begin
                if (load_bad) begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end else begin
                  ptr   <= CW'(in_data.load_index);
                  state <= S_LOAD;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          if (WW'(ptr) >= nbytes) begin
            res_status <= ST_NOFREE;
            state      <= S_DONE;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (rdata != FULL_BYTE) begin
            res_blk <= BLOCK_W'(blk_wide);
            state   <= S_DONE;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_FREE_RD: begin
          state <= S_FREE_WR;
        end
        S_FREE_WR: begin
          state <= S_DONE;
        end
        S_LOAD: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.allocated_block <= res_blk;
            out_data.status          <= res_status;
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // No command is taken while the store is still being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !in_ready)
    else $error("command accepted during store sweep");

  // One command at a time: ready drops right after a beat is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second command accepted while one is in work");

  // The scan pointer never runs past the scan limit
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CHK) |-> (WW'(ptr) < nbytes))
    else $error("scan read beyond bitmap length");

  // Status never carries the unused code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_DONE || out_data.status == ST_NOFREE ||
                   out_data.status == ST_RANGE))
    else $error("illegal status code on output");

endmodule

`default_nettype wire
